// ----- rtl/core/pta_pkg.sv -----
// Shared widths, register indexes, sequencer codes and control types for the
// trapezoidal PID controller. No dependencies.
`default_nettype none
package pta_pkg;

  // Field and register widths
  localparam int ERR_W   = 16;
  localparam int SUM_W   = 32;
  localparam int COEF_W  = 24;
  localparam int OUT_W   = 32;
  localparam int LIM_W   = 31;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 2;

  // Datapath widths
  localparam int DIFF_W      = ERR_W + 1;
  localparam int MB_W        = 33;
  localparam int PROD_W      = COEF_W + MB_W;
  localparam int INNER_W     = 58;
  localparam int ACC_W       = 82;
  localparam int SPLIT       = 29;
  localparam int ERR_SHIFT   = 17;
  localparam int FINAL_SHIFT = 25;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GAIN      = 2'd0;
  localparam logic [IDX_W-1:0] REG_INTEG     = 2'd1;
  localparam logic [IDX_W-1:0] REG_DERIV     = 2'd2;
  localparam logic [IDX_W-1:0] REG_SUM_LIMIT = 2'd3;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_MI   = 4'd2;
  localparam logic [3:0] ST_AI   = 4'd3;
  localparam logic [3:0] ST_AD   = 4'd4;
  localparam logic [3:0] ST_M0   = 4'd5;
  localparam logic [3:0] ST_M1   = 4'd6;
  localparam logic [3:0] ST_A1   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  // Multiplier coefficient select
  localparam logic [1:0] CA_GAIN  = 2'd0;
  localparam logic [1:0] CA_INTEG = 2'd1;
  localparam logic [1:0] CA_DERIV = 2'd2;

  // Multiplier operand select
  localparam logic [1:0] OB_SUM  = 2'd0;
  localparam logic [1:0] OB_DIFF = 2'd1;
  localparam logic [1:0] OB_LO   = 2'd2;
  localparam logic [1:0] OB_HI   = 2'd3;

  // Accumulator operations
  localparam logic [2:0] AO_HOLD      = 3'd0;
  localparam logic [2:0] AO_LOAD_ERR  = 3'd1;
  localparam logic [2:0] AO_ADD       = 3'd2;
  localparam logic [2:0] AO_ADD_X2    = 3'd3;
  localparam logic [2:0] AO_LOAD_PROD = 3'd4;
  localparam logic [2:0] AO_ADD_HI    = 3'd5;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       mul_en;
    logic [2:0] acc_op;
  } pta_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/pta_mac.sv -----
// Shared multiply-accumulate unit: one signed 24x33 multiplier with a
// registered product and an 82-bit accumulator. Depends on pta_pkg.
`default_nettype none
module pta_mac import pta_pkg::*; (
  input  wire logic                     clk,
  input  wire pta_ctrl_t                ctrl,
  input  wire logic signed [COEF_W-1:0] gain,
  input  wire logic signed [COEF_W-1:0] integ_gain,
  input  wire logic signed [COEF_W-1:0] deriv_gain,
  input  wire logic signed [SUM_W-1:0]  sum,
  input  wire logic signed [DIFF_W-1:0] diff,
  input  wire logic signed [ERR_W-1:0]  err,
  output logic signed [ACC_W-1:0]       acc
);

  logic signed [COEF_W-1:0] op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  always_comb begin
    case (ctrl.a_sel)
      CA_GAIN:  op_a = gain;
      CA_INTEG: op_a = integ_gain;
      CA_DERIV: op_a = deriv_gain;
      default:  op_a = gain;
    endcase
  end

  // Operand B is the sum, the difference, or the inner term split into an unsigned low part and a signed high part
  always_comb begin
    case (ctrl.b_sel)
      OB_SUM:  op_b = {{(MB_W-SUM_W){sum[SUM_W-1]}}, sum};
      OB_DIFF: op_b = {{(MB_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      OB_LO:   op_b = {{(MB_W-SPLIT){1'b0}}, acc_r[SPLIT-1:0]};
      OB_HI:   op_b = {{(MB_W-(INNER_W-SPLIT)){acc_r[INNER_W-1]}},
                       acc_r[INNER_W-1:SPLIT]};
      default: op_b = {{(MB_W-SUM_W){sum[SUM_W-1]}}, sum};
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (ctrl.acc_op)
      AO_HOLD:      acc_nxt = acc_r;
      AO_LOAD_ERR:  acc_nxt = {{(ACC_W-ERR_W-ERR_SHIFT){err[ERR_W-1]}}, err,
                               {ERR_SHIFT{1'b0}}};
      AO_ADD:       acc_nxt = acc_r + prod_ext;
      AO_ADD_X2:    acc_nxt = acc_r + (prod_ext <<< 1);
      AO_LOAD_PROD: acc_nxt = prod_ext;
      AO_ADD_HI:    acc_nxt = acc_r + (prod_ext <<< SPLIT);
      default:      acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/pid_trapezoid_antiwindup.sv -----
// Top level of the trapezoidal PID controller with anti-windup clamp.
// A sample passes through the sequencer states SUM, MI, AI, AD, M0, M1, A1
// and OUT; the shared multiplier runs four products in turn.
// The input stalls while a sample is in work; the next sample is taken while
// a result still waits in the output register.
// Reset (synchronous, rst_n low) clears the gains, limit, error history and
// error sum to zero and empties the output register.
`default_nettype none
module pid_trapezoid_antiwindup import pta_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  // Error sample channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ERR_W-1:0] in_error_sample,
  // Drive channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_drive_value,
  output logic                         out_sum_clamped
);

  localparam int SUM_X_W = SUM_W + 2;   // sum plus two error samples

  // Configuration registers
  logic signed [COEF_W-1:0] gain_r, integ_r, deriv_r;
  logic [LIM_W-1:0]         limit_r;

  // Controller state and sample in work
  logic [3:0]               state_r, state_nxt;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DIFF_W-1:0] diff_r;

  // Output register
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  drive_r;
  logic                     clamped_r;

  pta_ctrl_t                ctrl;
  logic signed [ACC_W-1:0]  acc;

  logic                     in_xfer;
  logic                     out_free;
  logic signed [SUM_X_W-1:0] sum_x;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W-1:0]  lim_pos, lim_neg;
  logic signed [SUM_W-1:0]  sum_clamp;
  logic                     clamp_hit;
  logic [ACC_W-1:FINAL_SHIFT+OUT_W-1] drive_top;
  logic signed [OUT_W-1:0]  drive_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Config writes take effect at once; write them only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      integ_r <= '0;
      deriv_r <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:      gain_r  <= cfg_data[COEF_W-1:0];
        REG_INTEG:     integ_r <= cfg_data[COEF_W-1:0];
        REG_DERIV:     deriv_r <= cfg_data[COEF_W-1:0];
        REG_SUM_LIMIT: limit_r <= cfg_data[LIM_W-1:0];
        default:       limit_r <= limit_r;
      endcase
    end
  end

  // Trapezoid: (e + p)/2 in Q.9 is the raw sum e + p; saturate to sum width
  assign sum_x = {{2{sum_r[SUM_W-1]}}, sum_r}
               + {{(SUM_X_W-ERR_W){err_r[ERR_W-1]}}, err_r}
               + {{(SUM_X_W-ERR_W){prev_r[ERR_W-1]}}, prev_r};

  always_comb begin
    if (sum_x[SUM_X_W-1:SUM_W-1] == {3{1'b0}} || sum_x[SUM_X_W-1:SUM_W-1] == {3{1'b1}}) begin
      sum_sat = sum_x[SUM_W-1:0];
    end else if (sum_x[SUM_X_W-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // Anti-windup clamp, applied after the integral term was formed
  assign lim_pos = {{(SUM_W-LIM_W){1'b0}}, limit_r};
  assign lim_neg = -lim_pos;

  always_comb begin
    sum_clamp = sum_r;
    clamp_hit = 1'b0;
    if (limit_r != '0) begin
      if (sum_r > lim_pos) begin
        sum_clamp = lim_pos;
        clamp_hit = 1'b1;
      end else if (sum_r < lim_neg) begin
        sum_clamp = lim_neg;
        clamp_hit = 1'b1;
      end
    end
  end

  // Drive: product shifted right (floor), then saturated to output width
  assign drive_top = acc[ACC_W-1:FINAL_SHIFT+OUT_W-1];

  always_comb begin
    if ((&drive_top) || !(|drive_top)) begin
      drive_sat = acc[FINAL_SHIFT+OUT_W-1:FINAL_SHIFT];
    end else if (acc[ACC_W-1]) begin
      drive_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // Sequencer: steps the products one at a time through the shared multiplier
  always_comb begin
    state_nxt   = state_r;
    ctrl.a_sel  = CA_GAIN;
    ctrl.b_sel  = OB_SUM;
    ctrl.mul_en = 1'b0;
    ctrl.acc_op = AO_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_MI;
      end
      ST_MI: begin
        ctrl.a_sel  = CA_INTEG;
        ctrl.b_sel  = OB_SUM;
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = AO_LOAD_ERR;
        state_nxt   = ST_AI;
      end
      ST_AI: begin
        ctrl.a_sel  = CA_DERIV;
        ctrl.b_sel  = OB_DIFF;
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = AO_ADD;
        state_nxt   = ST_AD;
      end
      ST_AD: begin
        ctrl.acc_op = AO_ADD_X2;
        state_nxt   = ST_M0;
      end
      ST_M0: begin
        ctrl.a_sel  = CA_GAIN;
        ctrl.b_sel  = OB_LO;
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_M1;
      end
      ST_M1: begin
        ctrl.a_sel  = CA_GAIN;
        ctrl.b_sel  = OB_HI;
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = AO_LOAD_PROD;
        state_nxt   = ST_A1;
      end
      ST_A1: begin
        ctrl.acc_op = AO_ADD_HI;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  pta_mac u_mac (
    .clk        (clk),
    .ctrl       (ctrl),
    .gain       (gain_r),
    .integ_gain (integ_r),
    .deriv_gain (deriv_r),
    .sum        (sum_r),
    .diff       (diff_r),
    .err        (err_r),
    .acc        (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SUM) begin
        sum_r <= sum_sat;
      end
      if (state_r == ST_OUT && out_free) begin
        sum_r       <= sum_clamp;
        prev_r      <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r <= in_error_sample;
    end
    if (state_r == ST_SUM) begin
      diff_r <= {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};
    end
    if (state_r == ST_OUT && out_free) begin
      drive_r   <= drive_sat;
      clamped_r <= clamp_hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;
  assign out_sum_clamped = clamped_r;

endmodule
`default_nettype wire

// ----- rtl/core/pta_checker.sv -----
// Port-level checker for the PID controller, bound to the top level.
// Depends on pta_pkg and pid_trapezoid_antiwindup.
`default_nettype none
module pta_checker import pta_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [OUT_W-1:0] out_drive_value,
  input wire logic                    out_sum_clamped
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_value)
                               && $stable(out_sum_clamped))
    else $error("stalled result changed");

  // Sample transfer starts work, so input stalls next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // A fresh result only appears at the end of work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind pid_trapezoid_antiwindup pta_checker u_pta_checker (.*);
`default_nettype wire

// ----- sim/tb_pid_trapezoid_antiwindup.sv -----
// Self-checking testbench for pid_trapezoid_antiwindup: directed, random and windup
// runs, with results checked against a cycle-free software copy of the control law.
// Depends on pta_pkg and the pid_trapezoid_antiwindup RTL.
`timescale 1ns / 1ps

module tb_pid_trapezoid_antiwindup;
  import pta_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 56;
  localparam int WINDUP_ITEMS  = 12;

  // Fixed-point alignment: error Q.8 -> inner Q.25, drive Q.41 -> Q.16
  localparam int ERR_ALIGN_SHIFT = 17;
  localparam int DRIVE_SHIFT     = 25;

  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]        COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]        COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]        UNITY    = 24'h010000;
  localparam logic [LIM_W-1:0]         LIM_MAX  = {LIM_W{1'b1}};
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic                    clamped;
  } drive_result_t;

  // Tracks controller state and configuration, predicts one drive per sample
  // and checks the drive stream in order.
  class pid_scoreboard;
    drive_result_t            expected_q[$];
    logic signed [COEF_W-1:0] kp, ki, kd;
    logic [LIM_W-1:0]         limit;
    logic signed [ERR_W-1:0]  prev_err;
    longint                   err_sum;
    int                       mismatches;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      limit = '0;
      prev_err = '0;
      err_sum = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GAIN:      kp = data[COEF_W-1:0];
        REG_INTEG:     ki = data[COEF_W-1:0];
        REG_DERIV:     kd = data[COEF_W-1:0];
        REG_SUM_LIMIT: limit = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [ERR_W-1:0] e);
      longint                ev, pv, lim, integ, deriv, inner;
      logic signed [127:0]   op_a, op_b, drive_wide, out_hi, out_lo;
      drive_result_t         r;
      ev = e;
      pv = prev_err;
      lim = limit;
      // Trapezoid (e + p)/2 in Q.9 is the raw sum e + p; saturate at sum width
      err_sum = err_sum + ev + pv;
      if (err_sum > SUM_MAX) err_sum = SUM_MAX;
      else if (err_sum < SUM_MIN) err_sum = SUM_MIN;
      integ = longint'(ki) * err_sum;
      deriv = 2 * (longint'(kd) * (ev - pv));
      inner = (ev <<< ERR_ALIGN_SHIFT) + integ + deriv;
      // Anti-windup acts only after the integral term used the raw sum
      r.clamped = 1'b0;
      if (lim != 0) begin
        if (err_sum > lim) begin
          err_sum = lim;
          r.clamped = 1'b1;
        end else if (err_sum < -lim) begin
          err_sum = -lim;
          r.clamped = 1'b1;
        end
      end
      op_a = kp;
      op_b = inner;
      drive_wide = (op_a * op_b) >>> DRIVE_SHIFT;
      out_hi = (128'sd1 <<< (OUT_W - 1)) - 1;
      out_lo = -out_hi - 1;
      if (drive_wide > out_hi) drive_wide = out_hi;
      else if (drive_wide < out_lo) drive_wide = out_lo;
      r.drive = drive_wide[OUT_W-1:0];
      prev_err = e;
      expected_q.push_back(r);
    endfunction

    function void flag(string msg);
      $error("%s", msg);
      mismatches++;
    endfunction

    function void check_result(logic signed [OUT_W-1:0] drive, logic clamped);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("drive transfer with no sample pending: drive_value %0d", drive));
        return;
      end
      want = expected_q.pop_front();
      if (drive !== want.drive)
        flag($sformatf("drive_value: expected %0d, got %0d", want.drive, drive));
      if (clamped !== want.clamped)
        flag($sformatf("sum_clamped: expected %0d, got %0d", want.clamped, clamped));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [ERR_W-1:0] in_error_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_drive_value;
  logic                    out_sum_clamped;

  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver stalls
  int idle_cycles = 0;

  pid_scoreboard sb;

  pid_trapezoid_antiwindup dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_sample (in_error_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .out_sum_clamped (out_sum_clamped)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Receiver: stall at random at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // Check every drive transfer; end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_drive_value, out_sum_clamped);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random filler for the register bits above the coefficient width
  function automatic logic [CFG_W-COEF_W-1:0] pad_bits();
    return (CFG_W-COEF_W)'($urandom);
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error();
    logic signed [ERR_W-1:0] v;
    case ($urandom_range(9))
      0: return ERR_MAX;
      1: return ERR_MIN;
      2: return '0;
      3, 4: begin
        // small deviations keep the loop out of saturation
        v = ERR_W'($urandom_range(512));
        return v - 16'sd256;
      end
      default: return ERR_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coeff();
    logic [COEF_W-1:0] v;
    case ($urandom_range(5))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3, 4: begin
        v = COEF_W'($urandom_range(1 << 18));
        return v - COEF_W'(1 << 17);
      end
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return LIM_MAX;
      2, 3: return LIM_W'($urandom_range(1, 1 << 20));
      default: return LIM_W'($urandom);
    endcase
  endfunction

  // Write one register; leave the write enable up for a following write
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic program_loop(input logic [COEF_W-1:0] kp, input logic [COEF_W-1:0] ki,
                              input logic [COEF_W-1:0] kd, input logic [LIM_W-1:0] lim);
    cfg_write(REG_GAIN, {pad_bits(), kp});
    cfg_write(REG_INTEG, {pad_bits(), ki});
    cfg_write(REG_DERIV, {pad_bits(), kd});
    cfg_write(REG_SUM_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  // Wait until every pending drive has come out, then let the pipe empty
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample and hold it until the transfer happens
  task automatic send_error(input logic signed [ERR_W-1:0] e);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_error_sample <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_sample(e);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: from reset the sum is zero, so the first sample lands the sum
    // exactly on the limit (no clamp), the next pushes past it, the third
    // drives it below the negative bound.
    program_loop(UNITY, 24'h000200, 24'h004000, 31'd100);
    send_error(16'sd100);
    send_error(16'sd1);
    send_error(-16'sd300);
    send_error(16'sd0);
    // Largest error swings in both directions
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MAX);
    send_error(-16'sd1);
    send_error(16'sd1);
    send_error(16'sd256);
    send_error(-16'sd256);
    in_valid <= 1'b0;

    // Extreme gains: drive overflow in both directions
    settle();
    program_loop(COEF_MAX, COEF_MIN, COEF_MAX, LIM_MAX);
    send_error(ERR_MAX);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MIN);
    send_error(16'sd0);
    in_valid <= 1'b0;
    settle();
    program_loop(COEF_MIN, COEF_MAX, COEF_MIN, '0);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(16'sd12345);
    in_valid <= 1'b0;

    // Random phases: new settings each time, cycling through idle patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      program_loop(pick_coeff(), pick_coeff(), pick_coeff(), pick_limit());
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_error(pick_error());
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          // hold the sender until the block has delivered everything
          in_valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    // Windup: push the sum far positive with no clamp, pull it back through
    // a tiny limit, then push it far negative, and finally run the largest
    // limit, which leaves the sum alone.
    settle();
    send_idle = 0;
    recv_stall = 0;
    program_loop(24'h000001, COEF_MAX, COEF_MIN, '0);
    for (int i = 0; i < WINDUP_ITEMS; i++) send_error(ERR_MAX);
    in_valid <= 1'b0;
    settle();
    program_loop(24'h000001, COEF_MAX, COEF_MIN, 31'd1);
    send_error(16'sd0);
    send_error(16'sd0);
    in_valid <= 1'b0;
    settle();
    program_loop(24'h000001, COEF_MAX, COEF_MIN, '0);
    for (int i = 0; i < WINDUP_ITEMS; i++) send_error(ERR_MIN);
    in_valid <= 1'b0;
    settle();
    program_loop(24'h000001, COEF_MAX, COEF_MIN, LIM_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MIN);
    in_valid <= 1'b0;

    // Drain and watch for stray transfers
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
